[rtl/tgi_pkg.sv]
// tgi_pkg: shared types, codes and constants of the trilinear grid interpolator
// no dependencies; used by tgi_front, tgi_back and the top level through scoped names
package tgi_pkg;

    localparam int AXIS_POINTS_DEF = 16;
    localparam int TABLE_DEPTH_DEF = 4096;

    localparam int CMD_W    = 2;
    localparam int AXSEL_W  = 2;
    localparam int PIDX_W   = 4;
    localparam int COORD_W  = 20;
    localparam int TADDR_W  = 12;
    localparam int VALUE_W  = 32;
    localparam int CNT_W    = 5;
    localparam int CFGIDX_W = 2;
    localparam int WGT_W    = 17;
    localparam int FRAC_W   = 16;

    localparam logic [WGT_W-1:0] ONE_WEIGHT = 17'h10000;

    // command codes
    localparam logic [CMD_W-1:0] CMD_GRID  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TABLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // axis codes
    localparam logic [AXSEL_W-1:0] AXIS_A = 2'd0;
    localparam logic [AXSEL_W-1:0] AXIS_B = 2'd1;
    localparam logic [AXSEL_W-1:0] AXIS_C = 2'd2;

    // configuration register indexes
    localparam logic [CFGIDX_W-1:0] CFG_POINTS_A = 2'd0;
    localparam logic [CFGIDX_W-1:0] CFG_POINTS_B = 2'd1;
    localparam logic [CFGIDX_W-1:0] CFG_POINTS_C = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [AXSEL_W-1:0] axis_select;
        logic [PIDX_W-1:0]  point_index;
        logic [COORD_W-1:0] coord_a;
        logic [COORD_W-1:0] coord_b;
        logic [COORD_W-1:0] coord_c;
        logic [TADDR_W-1:0] table_address;
        logic [VALUE_W-1:0] table_word;
    } item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SEARCH,
        S_LO,
        S_HI,
        S_WSET,
        S_DIV,
        S_C0,
        S_C1,
        S_C2,
        S_C3,
        S_OUT
    } seq_state_t;

endpackage

[rtl/trilinear_grid_interpolator_unit.sv]
// trilinear_grid_interpolator_unit: top level of the non-uniform grid trilinear interpolator
// depends on tgi_pkg, tgi_front, tgi_back (which holds tgi_ram)
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | in        | in_valid / in_stall  | cmd, axis_select, point_index, coords,
//           |           |                      | table_address, table_word
//   out     | out       | out_valid / out_stall| interpolated_value
//   cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// load words (grid point, table word) retire straight from the idle state
// a query runs per axis an init step, the binary search steps, the lo and hi reads,
// the weight set-up and the shared one-bit-per-cycle weight divider, then per corner
// C0..C3 for the eight corner reads through the single table read port, then S_OUT
// a two-word queue lets the front keep taking words while the back end works
// reset clears control state and sets all point counts to 16; grids and table
// are undefined until written
module trilinear_grid_interpolator_unit #(
    parameter int AXIS_POINTS = tgi_pkg::AXIS_POINTS_DEF,
    parameter int TABLE_DEPTH = tgi_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [tgi_pkg::CMD_W-1:0]           cmd,
    input  logic [tgi_pkg::AXSEL_W-1:0]         axis_select,
    input  logic [tgi_pkg::PIDX_W-1:0]          point_index,
    input  logic [tgi_pkg::COORD_W-1:0]         coord_a,
    input  logic [tgi_pkg::COORD_W-1:0]         coord_b,
    input  logic [tgi_pkg::COORD_W-1:0]         coord_c,
    input  logic [tgi_pkg::TADDR_W-1:0]         table_address,
    input  logic signed [tgi_pkg::VALUE_W-1:0]  table_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tgi_pkg::VALUE_W-1:0]  interpolated_value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tgi_pkg::CFGIDX_W-1:0]        cfg_index,
    input  logic [tgi_pkg::CNT_W-1:0]           cfg_data
);

    tgi_pkg::item_t in_item;
    tgi_pkg::item_t q_item;
    logic           q_valid;
    logic           q_pop;

    // pack the input word for the queue
    always_comb
    begin
        in_item.cmd = cmd;
        in_item.axis_select = axis_select;
        in_item.point_index = point_index;
        in_item.coord_a = coord_a;
        in_item.coord_b = coord_b;
        in_item.coord_c = coord_c;
        in_item.table_address = table_address;
        in_item.table_word = table_word;
    end

    // front: accept and classify, buffer up to two words
    tgi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: loads, search, weights, corner accumulate, result register
    tgi_back #(
        .AXIS_POINTS (AXIS_POINTS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_value (interpolated_value)
    );

endmodule

[rtl/tgi_ram.sv]
// tgi_ram: generic single write port, single read port ram with registered read
// no dependencies
module tgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tgi_front.sv]
// tgi_front: accepts input words, drops unused command codes, two-entry queue
// depends on tgi_pkg
module tgi_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  tgi_pkg::item_t                 in_item,
    output logic                           q_valid,
    output tgi_pkg::item_t                 q_item,
    input  logic                           q_pop
);

    tgi_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    logic           pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall && (in_item.cmd == tgi_pkg::CMD_GRID ||
                  in_item.cmd == tgi_pkg::CMD_TABLE || in_item.cmd == tgi_pkg::CMD_QUERY);
    assign pop = q_pop && (cnt_reg != 2'd0);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> cnt_reg == $past(cnt_reg) - 2'd1) else $error("pop count slip");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step");

endmodule

[rtl/tgi_back.sv]
// tgi_back: executes queued words; grid/table loads, binary search, weight divider,
// serial corner multiply-accumulate and result register; depends on tgi_pkg, tgi_ram
module tgi_back #(
    parameter int AXIS_POINTS = tgi_pkg::AXIS_POINTS_DEF,
    parameter int TABLE_DEPTH = tgi_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  tgi_pkg::item_t                      q_item,
    output logic                                q_pop,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tgi_pkg::CFGIDX_W-1:0]        cfg_index,
    input  logic [tgi_pkg::CNT_W-1:0]           cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tgi_pkg::VALUE_W-1:0]  out_value
);

    localparam int IW = $clog2(AXIS_POINTS);
    localparam int NW = IW + 1;
    localparam int FW = 3 * NW;
    localparam int TW = $clog2(TABLE_DEPTH);
    localparam int CW = tgi_pkg::COORD_W;
    localparam int WW = tgi_pkg::WGT_W;
    localparam int VW = tgi_pkg::VALUE_W;

    function automatic logic [NW-1:0] clamp_n(input logic [tgi_pkg::CNT_W-1:0] v);
        if (v < 5'd2)
            return NW'(2);
        else if (32'(v) > 32'(AXIS_POINTS))
            return NW'(AXIS_POINTS);
        else
            return NW'(v);
    endfunction

    function automatic logic [WW-1:0] pick_w(input logic [WW-1:0] w, input logic b);
        return b ? w : (tgi_pkg::ONE_WEIGHT - w);
    endfunction

    // configuration
    logic [tgi_pkg::CNT_W-1:0] pts_reg [3];

    // grids
    logic [CW-1:0] grid_a_reg [AXIS_POINTS];
    logic [CW-1:0] grid_b_reg [AXIS_POINTS];
    logic [CW-1:0] grid_c_reg [AXIS_POINTS];
    logic          grid_we;
    logic [31:0]   pidx_ext;
    logic [IW-1:0] rd_idx;
    logic [CW-1:0] grid_q;

    tgi_pkg::seq_state_t state_reg, state_next;
    logic [1:0]    ax_reg, ax_next;
    logic [CW-1:0] x_reg [3];
    logic [CW-1:0] x_next [3];
    logic [NW-1:0] n_reg [3];
    logic [NW-1:0] n_next [3];
    logic [2*NW-1:0] nbnc_reg, nbnc_next;
    logic [NW-1:0] first_reg, first_next;
    logic [NW-1:0] count_reg, count_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic          clo_reg, clo_next;
    logic          chi_reg, chi_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] den_reg, den_next;
    logic [15:0]   quo_reg, quo_next;
    logic [3:0]    bit_reg, bit_next;
    logic [IW-1:0] la_reg [3];
    logic [IW-1:0] la_next [3];
    logic [WW-1:0] w_reg [3];
    logic [WW-1:0] w_next [3];
    logic [2:0]    corner_reg, corner_next;
    logic [FW-1:0] part_reg, part_next;
    logic [33:0]   p1_reg, p1_next;
    logic [48:0]   p2_reg, p2_next;
    logic          inr_reg, inr_next;
    logic signed [57:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic          out_valid_reg, out_valid_next;
    logic signed [VW-1:0] out_value_reg, out_value_next;

    // combinational helpers
    logic [NW-1:0] n_cur, step, it;
    logic [CW-1:0] x_cur, x_eff;
    logic [WW-1:0] w_done;
    logic          ax_done;
    logic [CW:0]   rem2;
    logic [NW-1:0] a_idx, b_idx, c_idx;
    logic [FW-1:0] part_full;
    logic [2*NW-1:0] bterm;
    logic [FW-1:0] addr_full;
    logic [63:0]   addr64, taddr64;
    logic [50:0]   p2_full;
    logic signed [VW-1:0] val;
    logic signed [63:0] rnd;
    logic signed [39:0] t40;

    // table ram
    logic          ram_we, ram_re;
    logic [TW-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0] ram_rdata;

    tgi_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_item.table_word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

    assign pidx_ext = 32'(q_item.point_index);
    assign taddr64 = 64'(q_item.table_address);
    assign ram_waddr = taddr64[TW-1:0];
    assign ram_we = (state_reg == tgi_pkg::S_IDLE) && q_valid &&
                    (q_item.cmd == tgi_pkg::CMD_TABLE) && (taddr64 < 64'(TABLE_DEPTH));
    assign grid_we = (state_reg == tgi_pkg::S_IDLE) && q_valid &&
                     (q_item.cmd == tgi_pkg::CMD_GRID) && (pidx_ext < 32'(AXIS_POINTS));
    assign q_pop = (state_reg == tgi_pkg::S_IDLE) && q_valid;

    // single grid read port, address chosen by state
    always_comb
    begin
        case (ax_reg)
            2'd0:    grid_q = grid_a_reg[rd_idx];
            2'd1:    grid_q = grid_b_reg[rd_idx];
            default: grid_q = grid_c_reg[rd_idx];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (grid_we && q_item.axis_select == tgi_pkg::AXIS_A)
            grid_a_reg[pidx_ext[IW-1:0]] <= q_item.coord_a;
        if (grid_we && q_item.axis_select == tgi_pkg::AXIS_B)
            grid_b_reg[pidx_ext[IW-1:0]] <= q_item.coord_a;
        if (grid_we && q_item.axis_select == tgi_pkg::AXIS_C)
            grid_c_reg[pidx_ext[IW-1:0]] <= q_item.coord_a;
    end

    always_comb
    begin
        state_next = state_reg;
        ax_next = ax_reg;
        x_next = x_reg;
        n_next = n_reg;
        nbnc_next = nbnc_reg;
        first_next = first_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        clo_next = clo_reg;
        chi_next = chi_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        bit_next = bit_reg;
        la_next = la_reg;
        w_next = w_reg;
        corner_next = corner_reg;
        part_next = part_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        inr_next = inr_reg;
        prod_next = prod_reg;
        acc_next = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_value_next = out_value_reg;
        ram_re = 1'b0;
        ram_raddr = '0;
        rd_idx = '0;

        n_cur = n_reg[ax_reg];
        x_cur = x_reg[ax_reg];
        step = count_reg >> 1;
        it = first_reg + step;
        x_eff = clo_reg ? lo_reg : (chi_reg ? hi_reg : x_cur);
        w_done = '0;
        ax_done = 1'b0;
        rem2 = {rem_reg, 1'b0};
        a_idx = NW'(la_reg[0]) + NW'(corner_reg[2]);
        b_idx = NW'(la_reg[1]) + NW'(corner_reg[1]);
        c_idx = NW'(la_reg[2]) + NW'(corner_reg[0]);
        part_full = FW'(a_idx) * FW'(nbnc_reg);
        bterm = (2*NW)'(b_idx) * (2*NW)'(n_reg[2]);
        addr_full = part_reg + FW'(bterm) + FW'(c_idx);
        addr64 = 64'(addr_full);
        p2_full = 51'(p1_reg) * 51'(pick_w(w_reg[2], corner_reg[0]));
        val = inr_reg ? $signed(ram_rdata) : '0;
        rnd = acc_reg + 64'sd8388608;
        t40 = 40'(rnd >>> 24);

        case (state_reg)
            tgi_pkg::S_IDLE:
            begin
                if (q_valid && q_item.cmd == tgi_pkg::CMD_QUERY)
                begin
                    x_next[0] = q_item.coord_a;
                    x_next[1] = q_item.coord_b;
                    x_next[2] = q_item.coord_c;
                    n_next[0] = clamp_n(pts_reg[0]);
                    n_next[1] = clamp_n(pts_reg[1]);
                    n_next[2] = clamp_n(pts_reg[2]);
                    nbnc_next = (2*NW)'(clamp_n(pts_reg[1])) * (2*NW)'(clamp_n(pts_reg[2]));
                    ax_next = 2'd0;
                    state_next = tgi_pkg::S_INIT;
                end
            end
            tgi_pkg::S_INIT:
            begin
                first_next = '0;
                count_next = n_cur;
                clo_next = 1'b0;
                chi_next = 1'b0;
                state_next = tgi_pkg::S_SEARCH;
            end
            tgi_pkg::S_SEARCH:
            begin
                rd_idx = it[IW-1:0];
                if (count_reg == '0)
                begin
                    if (first_reg == '0)
                    begin
                        clo_next = 1'b1;
                        idx_next = NW'(1);
                    end
                    else if (first_reg == n_cur)
                    begin
                        chi_next = 1'b1;
                        idx_next = n_cur - NW'(1);
                    end
                    else
                    begin
                        idx_next = first_reg;
                    end
                    state_next = tgi_pkg::S_LO;
                end
                else if (!(x_cur < grid_q))
                begin
                    first_next = it + NW'(1);
                    count_next = count_reg - step - NW'(1);
                end
                else
                begin
                    count_next = step;
                end
            end
            tgi_pkg::S_LO:
            begin
                rd_idx = IW'(idx_reg - NW'(1));
                lo_next = grid_q;
                la_next[ax_reg] = IW'(idx_reg - NW'(1));
                state_next = tgi_pkg::S_HI;
            end
            tgi_pkg::S_HI:
            begin
                rd_idx = idx_reg[IW-1:0];
                hi_next = grid_q;
                state_next = tgi_pkg::S_WSET;
            end
            tgi_pkg::S_WSET:
            begin
                if (hi_reg <= lo_reg || x_eff <= lo_reg)
                begin
                    w_done = '0;
                    ax_done = 1'b1;
                end
                else if (x_eff >= hi_reg)
                begin
                    w_done = tgi_pkg::ONE_WEIGHT;
                    ax_done = 1'b1;
                end
                else
                begin
                    rem_next = x_eff - lo_reg;
                    den_next = hi_reg - lo_reg;
                    quo_next = '0;
                    bit_next = '0;
                    state_next = tgi_pkg::S_DIV;
                end
            end
            tgi_pkg::S_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_next = CW'(rem2 - {1'b0, den_reg});
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[CW-1:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                bit_next = bit_reg + 4'd1;
                if (bit_reg == 4'd15)
                begin
                    w_done = {1'b0, quo_next};
                    ax_done = 1'b1;
                end
            end
            tgi_pkg::S_C0:
            begin
                part_next = part_full;
                p1_next = 34'(pick_w(w_reg[0], corner_reg[2])) *
                          34'(pick_w(w_reg[1], corner_reg[1]));
                state_next = tgi_pkg::S_C1;
            end
            tgi_pkg::S_C1:
            begin
                p2_next = p2_full[48:0];
                inr_next = (addr64 < 64'(TABLE_DEPTH));
                ram_re = 1'b1;
                ram_raddr = addr64[TW-1:0];
                state_next = tgi_pkg::S_C2;
            end
            tgi_pkg::S_C2:
            begin
                prod_next = 58'(val) * $signed({1'b0, p2_reg[48:24]});
                state_next = tgi_pkg::S_C3;
            end
            tgi_pkg::S_C3:
            begin
                acc_next = acc_reg + 64'(prod_reg);
                corner_next = corner_reg + 3'd1;
                state_next = (corner_reg == 3'd7) ? tgi_pkg::S_OUT : tgi_pkg::S_C0;
            end
            tgi_pkg::S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (t40 > 40'sd2147483647)
                        out_value_next = 32'sh7FFFFFFF;
                    else if (t40 < -40'sd2147483648)
                        out_value_next = 32'sh80000000;
                    else
                        out_value_next = t40[VW-1:0];
                    state_next = tgi_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tgi_pkg::S_IDLE;
            end
        endcase

        if (ax_done)
        begin
            w_next[ax_reg] = w_done;
            if (ax_reg == 2'd2)
            begin
                corner_next = '0;
                acc_next = '0;
                state_next = tgi_pkg::S_C0;
            end
            else
            begin
                ax_next = ax_reg + 2'd1;
                state_next = tgi_pkg::S_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tgi_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            pts_reg[0] <= 5'd16;
            pts_reg[1] <= 5'd16;
            pts_reg[2] <= 5'd16;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_index == tgi_pkg::CFG_POINTS_A)
                pts_reg[0] <= cfg_data;
            if (cfg_valid && cfg_index == tgi_pkg::CFG_POINTS_B)
                pts_reg[1] <= cfg_data;
            if (cfg_valid && cfg_index == tgi_pkg::CFG_POINTS_C)
                pts_reg[2] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg <= ax_next;
        x_reg <= x_next;
        n_reg <= n_next;
        nbnc_reg <= nbnc_next;
        first_reg <= first_next;
        count_reg <= count_next;
        idx_reg <= idx_next;
        clo_reg <= clo_next;
        chi_reg <= chi_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        bit_reg <= bit_next;
        la_reg <= la_next;
        w_reg <= w_next;
        corner_reg <= corner_next;
        part_reg <= part_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        inr_reg <= inr_next;
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        out_value_reg <= out_value_next;
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == tgi_pkg::S_IDLE) else $error("queue popped while busy");
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == tgi_pkg::S_OUT)
        else $error("result appeared outside output step");
    a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tgi_pkg::S_C0 |-> (w_reg[0] <= tgi_pkg::ONE_WEIGHT &&
        w_reg[1] <= tgi_pkg::ONE_WEIGHT && w_reg[2] <= tgi_pkg::ONE_WEIGHT))
        else $error("weight out of range");
    a_ram_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tgi_pkg::S_C2 |-> $past(state_reg) == tgi_pkg::S_C1)
        else $error("table data used without read");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking testbench for trilinear_grid_interpolator_unit
// depends on tgi_pkg and the rtl of the unit; a built-in predictor checks every output word

module tb;

    localparam logic [tgi_pkg::CFGIDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped register index
    localparam logic [tgi_pkg::CMD_W-1:0]    CMD_NONE  = 2'd3;   // command the unit ignores
    localparam logic [tgi_pkg::AXSEL_W-1:0]  AXIS_NONE = 2'd3;   // axis code the unit ignores
    localparam int SETTLE_CYCLES = 300;                 // covers one full query in flight
    localparam int CYCLE_LIMIT   = 1500000;

    logic clk = 1'b1;
    logic rst_n = 1'b0;

    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [tgi_pkg::CMD_W-1:0]           cmd = '0;
    logic [tgi_pkg::AXSEL_W-1:0]         axis_select = '0;
    logic [tgi_pkg::PIDX_W-1:0]          point_index = '0;
    logic [tgi_pkg::COORD_W-1:0]         coord_a = '0;
    logic [tgi_pkg::COORD_W-1:0]         coord_b = '0;
    logic [tgi_pkg::COORD_W-1:0]         coord_c = '0;
    logic [tgi_pkg::TADDR_W-1:0]         table_address = '0;
    logic signed [tgi_pkg::VALUE_W-1:0]  table_word = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [tgi_pkg::VALUE_W-1:0]  interpolated_value;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [tgi_pkg::CFGIDX_W-1:0]        cfg_index = '0;
    logic [tgi_pkg::CNT_W-1:0]           cfg_data = '0;

    trilinear_grid_interpolator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .axis_select(axis_select), .point_index(point_index),
        .coord_a(coord_a), .coord_b(coord_b), .coord_c(coord_c),
        .table_address(table_address), .table_word(table_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .interpolated_value(interpolated_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock: 4 ns period
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // words waiting to go out, and interpolation results still owed by the unit
    tgi_pkg::item_t                     pending_words[$];
    logic signed [tgi_pkg::VALUE_W-1:0] owed_values[$];
    int                                 error_count = 0;

    // mirror of the unit's state, updated as words are accepted
    logic [tgi_pkg::COORD_W-1:0]        grid_m[3][16];
    logic signed [tgi_pkg::VALUE_W-1:0] table_m[4096];
    int                                 points_m[3] = '{16, 16, 16};

    // stimulus-side copy of the grids, used to aim query coordinates
    logic [tgi_pkg::COORD_W-1:0]        plan_grid[3][16];
    int                                 plan_points[3];

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int clamp_points(input int n);
        if (n < 2)
            return 2;
        if (n > 16)
            return 16;
        return n;
    endfunction

    // upper-bound search plus clamp; returns lower cell index and upper weight
    function automatic void find_cell(input int ax, input int n,
                                      input logic [tgi_pkg::COORD_W-1:0] xin,
                                      output int lower, output longint wup);
        int     first;
        int     count;
        int     step;
        int     idx;
        longint x;
        longint lo;
        longint hi;
        first = 0;
        count = n;
        x = longint'(xin);
        while (count > 0)
        begin
            step = count / 2;
            if (!(x < longint'(grid_m[ax][first + step])))
            begin
                first = first + step + 1;
                count = count - step - 1;
            end
            else
                count = step;
        end
        idx = first;
        if (idx == 0)
        begin
            x = longint'(grid_m[ax][0]);
            idx = 1;
        end
        else if (idx == n)
        begin
            x = longint'(grid_m[ax][n - 1]);
            idx = n - 1;
        end
        lo = longint'(grid_m[ax][idx - 1]);
        hi = longint'(grid_m[ax][idx]);
        lower = idx - 1;
        if (hi <= lo || x <= lo)
            wup = 0;
        else if (x >= hi)
            wup = 65536;
        else
            wup = ((x - lo) << 16) / (hi - lo);
    endfunction

    // apply one accepted word to the mirror; queries add an owed value
    function automatic void interpolate_word(input tgi_pkg::item_t w);
        int     low[3];
        longint wup[3];
        longint wt[3][2];
        longint cw;
        longint addr;
        longint sum;
        longint res;
        logic [tgi_pkg::COORD_W-1:0] xs[3];
        xs[0] = w.coord_a;
        xs[1] = w.coord_b;
        xs[2] = w.coord_c;
        case (w.cmd)
            tgi_pkg::CMD_GRID:
            begin
                if (w.axis_select == tgi_pkg::AXIS_A)
                    grid_m[0][w.point_index] = w.coord_a;
                else if (w.axis_select == tgi_pkg::AXIS_B)
                    grid_m[1][w.point_index] = w.coord_a;
                else if (w.axis_select == tgi_pkg::AXIS_C)
                    grid_m[2][w.point_index] = w.coord_a;
            end
            tgi_pkg::CMD_TABLE:
                table_m[w.table_address] = w.table_word;
            tgi_pkg::CMD_QUERY:
            begin
                for (int ax = 0; ax < 3; ax++)
                begin
                    find_cell(ax, points_m[ax], xs[ax], low[ax], wup[ax]);
                    wt[ax][0] = 65536 - wup[ax];
                    wt[ax][1] = wup[ax];
                end
                sum = 0;
                for (int i = 0; i < 2; i++)
                    for (int j = 0; j < 2; j++)
                        for (int k = 0; k < 2; k++)
                        begin
                            cw = (wt[0][i] * wt[1][j] * wt[2][k]) >>> 24;
                            addr = longint'(low[0] + i) * points_m[1] * points_m[2]
                                 + longint'(low[1] + j) * points_m[2] + (low[2] + k);
                            if (addr < 4096)
                                sum += longint'(table_m[addr]) * cw;
                        end
                // round half up, floor shift on the biased sum
                res = (sum + (longint'(1) << 23)) >>> 24;
                if (res > 64'sd2147483647)
                    res = 64'sd2147483647;
                if (res < -64'sd2147483648)
                    res = -64'sd2147483648;
                owed_values = {owed_values, res[31:0]};
            end
            default:
                ;
        endcase
    endfunction

    // driver: bursts of words with random gaps between them
    int burst_left = 4;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 4;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                interpolate_word('{cmd, axis_select, point_index, coord_a, coord_b, coord_c,
                                   table_address, table_word});
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    tgi_pkg::item_t w;
                    w = pending_words.pop_front();
                    cmd           <= w.cmd;
                    axis_select   <= w.axis_select;
                    point_index   <= w.point_index;
                    coord_a       <= w.coord_a;
                    coord_b       <= w.coord_b;
                    coord_c       <= w.coord_c;
                    table_address <= w.table_address;
                    table_word    <= w.table_word;
                    in_valid      <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // some bursts run back to back
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall: out_stall follows a randomly picked mode (none, light, heavy)
    int stall_tick = 0;
    int stall_mode = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            stall_tick++;
            if (stall_tick % 97 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // monitor: compare each output word with the oldest owed value
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_values.size() == 0)
                report_mismatch($sformatf("unexpected output %h", interpolated_value));
            else
            begin
                logic signed [tgi_pkg::VALUE_W-1:0] want;
                want = owed_values.pop_front();
                if (interpolated_value !== want)
                    report_mismatch($sformatf("interpolated_value got %h want %h",
                                              interpolated_value, want));
            end
        end
    end

    // run limit
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("trilinear_grid_interpolator_unit: mismatch");
            $finish;
        end
    end

    function automatic tgi_pkg::item_t noise_word();
        tgi_pkg::item_t w;
        w = $bits(tgi_pkg::item_t)'({$urandom, $urandom, $urandom, $urandom});
        return w;
    endfunction

    task automatic enqueue_word(input tgi_pkg::item_t w);
        pending_words = {pending_words, w};
    endtask

    task automatic load_grid(input logic [tgi_pkg::AXSEL_W-1:0] ax, input int idx,
                             input logic [tgi_pkg::COORD_W-1:0] val);
        tgi_pkg::item_t w;
        w = noise_word();
        w.cmd = tgi_pkg::CMD_GRID;
        w.axis_select = ax;
        w.point_index = tgi_pkg::PIDX_W'(idx);
        w.coord_a = val;
        enqueue_word(w);
    endtask

    task automatic load_table(input int addr, input logic [tgi_pkg::VALUE_W-1:0] val);
        tgi_pkg::item_t w;
        w = noise_word();
        w.cmd = tgi_pkg::CMD_TABLE;
        w.table_address = tgi_pkg::TADDR_W'(addr);
        w.table_word = val;
        enqueue_word(w);
    endtask

    function automatic logic [tgi_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    // coordinate for one axis: aimed inside the grid, on a point, or anywhere
    function automatic logic [tgi_pkg::COORD_W-1:0] pick_coord(input int ax, input int k);
        int n;
        n = plan_points[ax];
        if (k < 20)
        begin
            case (k % 4)
                0: return plan_grid[ax][$urandom_range(0, n - 1)];
                1: return '1;
                2: return '0;
                default: return plan_grid[ax][n - 1];
            endcase
        end
        case ($urandom_range(0, 9))
            0: return tgi_pkg::COORD_W'($urandom);
            1: return plan_grid[ax][$urandom_range(0, n - 1)];
            default: return tgi_pkg::COORD_W'($urandom_range(plan_grid[ax][0],
                                                             plan_grid[ax][n - 1]));
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_words.size() > 0 || in_valid || owed_values.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [tgi_pkg::CFGIDX_W-1:0] idx,
                                  input logic [tgi_pkg::CNT_W-1:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx != CFG_SPARE)
            points_m[idx] = clamp_points(val);
        cfg_valid <= 1'b0;
    endtask

    // one setting of the point counts: reload grids and table, then queries mixed with stray and load words
    task automatic run_phase(input int ca, input int cb, input int cc, input int queries,
                             input bit rough);
        int span;
        int words;
        tgi_pkg::item_t w;
        wait_idle();
        write_register(tgi_pkg::CFG_POINTS_A, tgi_pkg::CNT_W'(ca));
        write_register(tgi_pkg::CFG_POINTS_B, tgi_pkg::CNT_W'(cb));
        write_register(tgi_pkg::CFG_POINTS_C, tgi_pkg::CNT_W'(cc));
        plan_points[0] = clamp_points(ca);
        plan_points[1] = clamp_points(cb);
        plan_points[2] = clamp_points(cc);
        for (int ax = 0; ax < 3; ax++)
        begin
            span = 1048575 / plan_points[ax];
            plan_grid[ax][0] = tgi_pkg::COORD_W'($urandom_range(0, span));
            for (int i = 1; i < plan_points[ax]; i++)
                // a rough grid may repeat or step back a point
                plan_grid[ax][i] = rough && $urandom_range(0, 2) == 0
                                 ? tgi_pkg::COORD_W'(plan_grid[ax][i - 1] -
                                                     $urandom_range(0, 3))
                                 : tgi_pkg::COORD_W'(plan_grid[ax][i - 1] +
                                                     $urandom_range(1, span));
            for (int i = 0; i < plan_points[ax]; i++)
                load_grid(tgi_pkg::AXSEL_W'(ax), i, plan_grid[ax][i]);
        end
        words = plan_points[0] * plan_points[1] * plan_points[2];
        for (int a = 0; a < words; a++)
            load_table(a, pick_value());
        for (int k = 0; k < queries; k++)
        begin
            case ($urandom_range(0, 19))
                0: enqueue_word(noise_word());  // may be any command
                1:
                begin
                    w = noise_word();
                    w.cmd = CMD_NONE;
                    enqueue_word(w);
                end
                2: load_grid(AXIS_NONE, $urandom_range(0, 15),
                             tgi_pkg::COORD_W'($urandom));
                3: load_table($urandom_range(0, words - 1), pick_value());
                4: load_table($urandom_range(0, 4095), pick_value());
                default:
                begin
                    w = noise_word();
                    w.cmd = tgi_pkg::CMD_QUERY;
                    w.coord_a = pick_coord(0, k);
                    w.coord_b = pick_coord(1, k);
                    w.coord_c = pick_coord(2, k);
                    enqueue_word(w);
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // unmapped index must leave the counts alone
        write_register(CFG_SPARE, tgi_pkg::CNT_W'($urandom));
        // out-of-range counts clamp to the ends
        run_phase(0, 1, 31, 20, 1'b0);
        run_phase(2, 2, 2, 80, 1'b1);
        run_phase(16, 2, 3, 110, 1'b0);
        run_phase(3, 16, 2, 110, 1'b0);
        run_phase(2, 3, 16, 110, 1'b0);
        run_phase(16, 16, 2, 150, 1'b0);
        run_phase(5, 4, 3, 120, 1'b1);
        run_phase(17, 2, 1, 100, 1'b0);
        wait_idle();
        if (error_count == 0)
            $display("trilinear_grid_interpolator_unit: match");
        else
            $display("trilinear_grid_interpolator_unit: mismatch");
        $finish;
    end

endmodule

[filelist.f]
rtl/tgi_pkg.sv
rtl/tgi_ram.sv
rtl/tgi_front.sv
rtl/tgi_back.sv
rtl/trilinear_grid_interpolator_unit.sv
tb/sv/tb.sv
